// File: rtl/wildcard_byte_pattern_scan_defines.svh
// ----------------------------------------------------------------------------
// wildcard byte pattern scan: assertion macros
// shared property forms for the scanner's concurrent checks
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WBPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps check failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define WBPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps check failed: next-cycle implication");

`endif

// File: rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// types and constants shared by the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

    // pattern storage and field widths
    localparam int PAT_STORE   = 16;
    localparam int IDX_W       = $clog2(PAT_STORE);
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int CARE_W      = 2 * PAT_STORE;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAT_LOW   = 3'd0,
        CFG_PAT_HIGH  = 3'd1,
        CFG_CARE_MASK = 3'd2,
        CFG_PAT_LEN   = 3'd3,
        CFG_START     = 3'd4,
        CFG_END       = 3'd5
    } cfg_index_t;

    // bytes packed with element 0 in the low bits
    typedef logic [PAT_STORE-1:0][7:0] byte_vec_t;

endpackage

// File: rtl/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// nibble-wise compare of the newest window bytes against the pattern
// ----------------------------------------------------------------------------
module wbps_match (
    input  wbps_pkg::byte_vec_t          recent,
    input  wbps_pkg::byte_vec_t          pattern,
    input  logic [wbps_pkg::CARE_W-1:0]  care,
    input  logic [wbps_pkg::LEN_W-1:0]   eff_len,
    output logic                         window_ok
);
    import wbps_pkg::*;

    // pattern byte k lines up with the byte that arrived eff_len-1-k ago
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        logic [7:0]       have;
        logic [7:0]       mask;
        window_ok = 1'b1;
        for (int k = 0; k < PAT_STORE; k++)
        begin
            pos  = eff_len - LEN_W'(k) - LEN_W'(1);
            have = recent[pos[IDX_W-1:0]];
            mask = {{4{care[2*k+1]}}, {4{care[2*k]}}};
            if ((LEN_W'(k) < eff_len) && (((have ^ pattern[k]) & mask) != 8'h00))
            begin
                window_ok = 1'b0;
            end
        end
    end

endmodule

// File: rtl/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// streaming byte scanner with nibble wildcards and an address window
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock. Each accepted byte is shifted into a
// window of recent bytes and the newest pattern_len bytes are compared with
// the pattern in the same cycle; a result (found with its start address, or
// found=0 on a last byte without match) lands in the output register in the
// cycle after the byte is taken. The window compare is combinational, so
// a new byte can be taken every clock; the input stalls only while a
// result sits in the output register and the output side is stalled.
// After a match no further results come until a transaction with restart
// set. Configuration writes are taken at any time but must only be made
// while the scanner is idle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic [wbps_pkg::ADDR_W-1:0]      byte_address,
    input  logic                             restart,
    input  logic                             last_byte,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [wbps_pkg::ADDR_W-1:0]      match_address,
    // configuration port
    input  logic                             cfg_write,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wbps_pkg::*;

    `include "wildcard_byte_pattern_scan_defines.svh"

    localparam int WIN_DEPTH = (PATTERN_BYTES < PAT_STORE) ? PATTERN_BYTES : PAT_STORE;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int CMP_W     = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    // configuration registers
    logic [63:0]       pat_low_reg;
    logic [63:0]       pat_high_reg;
    logic [CARE_W-1:0] care_reg;
    logic [LEN_W-1:0]  pat_len_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] end_reg;

    // scan state
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              seen_reg;
    logic              seen_next;

    // output register
    logic              out_valid_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              in_accept;
    byte_vec_t         recent;
    byte_vec_t         pattern;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  len_m1;
    logic [ADDR_W-1:0] win_start;
    logic              seen_eff;
    logic              fill_ok;
    logic              addr_ok;
    logic              start_ok;
    logic              end_ok;
    logic              window_ok;
    logic              hit;
    logic              emit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            pat_len_reg  <= LEN_W'(1);
            start_reg    <= '0;
            end_reg      <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PAT_LOW:   pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH:  pat_high_reg <= cfg_data;
                CFG_CARE_MASK: care_reg     <= cfg_data[CARE_W-1:0];
                CFG_PAT_LEN:   pat_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_START:     start_reg    <= cfg_data[ADDR_W-1:0];
                CFG_END:       end_reg      <= cfg_data[ADDR_W-1:0];
                default:       ;
            endcase
        end
    end

    // handshake
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // byte history: newest incoming byte first, older bytes behind it
    assign recent[0] = data_byte;
    if (WIN_DEPTH > 1)
    begin : g_hist
        logic [WIN_DEPTH-2:0][7:0] hist_reg;

        always_ff @(posedge clk)
        begin
            if (in_accept)
            begin
                hist_reg[0] <= data_byte;
                for (int i = 1; i < WIN_DEPTH - 1; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
            end
        end

        for (genvar j = 1; j < PAT_STORE; j++)
        begin : g_tap
            if (j < WIN_DEPTH)
            begin : g_used
                assign recent[j] = hist_reg[j-1];
            end
            else
            begin : g_pad
                assign recent[j] = 8'h00;
            end
        end
    end
    else
    begin : g_no_hist
        for (genvar j = 1; j < PAT_STORE; j++)
        begin : g_pad
            assign recent[j] = 8'h00;
        end
    end

    // effective pattern length, clamped to one and to the window depth
    always_comb
    begin
        if (pat_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (pat_len_reg > LEN_W'(WIN_DEPTH))
        begin
            eff_len = LEN_W'(WIN_DEPTH);
        end
        else
        begin
            eff_len = pat_len_reg;
        end
    end

    assign pattern = {pat_high_reg, pat_low_reg};

    wbps_match u_match (
        .recent    (recent),
        .pattern   (pattern),
        .care      (care_reg),
        .eff_len   (eff_len),
        .window_ok (window_ok)
    );

    // window fill after this byte, saturating at the window depth
    always_comb
    begin
        if (restart)
        begin
            fill_next = FILL_W'(1);
        end
        else if (fill_reg == FILL_W'(WIN_DEPTH))
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    // address bounds of the candidate window
    assign len_m1    = eff_len - LEN_W'(1);
    assign win_start = byte_address - ADDR_W'(len_m1);
    assign fill_ok   = CMP_W'(fill_next) >= CMP_W'(eff_len);
    assign addr_ok   = byte_address >= ADDR_W'(len_m1);
    assign start_ok  = win_start >= start_reg;
    assign end_ok    = ({1'b0, win_start} + (ADDR_W + 1)'(eff_len)) < {1'b0, end_reg};

    // match decision
    assign seen_eff  = restart ? 1'b0 : seen_reg;
    assign hit       = !seen_eff && fill_ok && addr_ok && start_ok && end_ok && window_ok;
    assign emit      = !seen_eff && (hit || last_byte);
    assign seen_next = seen_eff || hit;

    // scan state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            seen_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            fill_reg <= fill_next;
            seen_reg <= seen_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            found_reg <= hit;
            addr_reg  <= hit ? win_start : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

    // checks
    `WBPS_ASSERT_IMP(a_nofind_zero_addr, out_valid_reg && !found_reg, addr_reg == '0)
    `WBPS_ASSERT_IMP(a_stall_only_full, in_stall, out_valid_reg)
    `WBPS_ASSERT_NXT(a_hit_sets_seen, in_accept && hit, seen_reg && out_valid_reg && found_reg)

endmodule
